>>> sv/psr_pkg.sv
// Shared constants and types of the packet sequence reorder buffer.
`timescale 1ns / 1ps

package psr_pkg;

  localparam int WINDOW_DEFAULT = 16;
  localparam int SEQ_W          = 32;
  localparam int PAY_W          = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_UNRELIABLE = 2'd0;
  localparam logic [1:0] REG_RX_DISABLE = 2'd1;
  localparam logic [1:0] REG_IGNORE     = 2'd2;

  typedef struct packed {
    logic unreliable;
    logic rx_disabled;
    logic ignore_in;
  } mode_t;

endpackage

>>> sv/psr_cfg.sv
// Configuration registers of the reorder buffer behind an APB-style port.
`timescale 1ns / 1ps

module psr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [psr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [psr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output psr_pkg::mode_t                    mode
);

  psr_pkg::mode_t mode_r;
  psr_pkg::mode_t mode_nxt;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign mode    = mode_r;

  always_comb begin
    mode_nxt = mode_r;
    if (wr_en) begin
      case (reg_idx)
        psr_pkg::REG_UNRELIABLE: mode_nxt.unreliable  = pwdata[0];
        psr_pkg::REG_RX_DISABLE: mode_nxt.rx_disabled = pwdata[0];
        psr_pkg::REG_IGNORE:     mode_nxt.ignore_in   = pwdata[0];
        default:                 mode_nxt = mode_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      psr_pkg::REG_UNRELIABLE: prdata[0] = mode_r.unreliable;
      psr_pkg::REG_RX_DISABLE: prdata[0] = mode_r.rx_disabled;
      psr_pkg::REG_IGNORE:     prdata[0] = mode_r.ignore_in;
      default:                 prdata    = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

endmodule

>>> sv/psr_store.sv
// Reorder store: payload memory with registered read and per-slot valid flags.
`timescale 1ns / 1ps

module psr_store #(
  parameter int WINDOW = psr_pkg::WINDOW_DEFAULT,
  parameter int PW     = $clog2(WINDOW)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [PW-1:0]                wr_addr,
  input  logic [psr_pkg::PAY_W-1:0]    wr_data,
  input  logic                         clr_en,
  input  logic [PW-1:0]                clr_addr,
  input  logic                         rd_en,
  input  logic [PW-1:0]                rd_addr,
  output logic [psr_pkg::PAY_W-1:0]    rd_data,
  output logic [WINDOW-1:0]            valid
);

  logic [psr_pkg::PAY_W-1:0] mem [WINDOW];
  logic [psr_pkg::PAY_W-1:0] rd_data_r;
  logic [WINDOW-1:0]         valid_r;
  logic [WINDOW-1:0]         valid_nxt;

  assign rd_data = rd_data_r;
  assign valid   = valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    if (clr_en) begin
      valid_nxt[clr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> sv/packet_sequence_reorder_top.sv
// Top level of the packet sequence reorder buffer: request sequencer and output register.
`timescale 1ns / 1ps

// Receive-side reorder buffer for numbered packets.
// Input channel: in_valid/in_stall with in_sequence_number and in_payload_handle.
// Output channel: out_valid/out_stall with out_payload, out_sequence,
// out_from_store and out_last_of_run; the last flag marks the final result of a request.
// Configuration: APB-style port, registers at byte addresses 0, 4 and 8
// (unreliable mode, receive disabled, ignore incoming), bit 0 of each.
// A request is taken when the block is idle and its output register is free or
// being emptied. Its first result appears in the output register in the cycle after
// acceptance; further packets are then drained from the store through the registered
// read of the payload memory, and no new request is taken until draining ends. A
// stored or dropped request leaves the block idle.
// While the receiver stalls, the held result stays put and draining pauses.
// Reset clears the last delivered number to zero (the first expected number is 1),
// all store valid flags and the mode registers; no clearing pass is needed.
// Held packets live in a circular store of WINDOW slots indexed from a head pointer.

module packet_sequence_reorder_top #(
  parameter int WINDOW = psr_pkg::WINDOW_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [psr_pkg::SEQ_W-1:0]         in_sequence_number,
  input  logic [psr_pkg::PAY_W-1:0]         in_payload_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [psr_pkg::PAY_W-1:0]         out_payload,
  output logic [psr_pkg::SEQ_W-1:0]         out_sequence,
  output logic                              out_from_store,
  output logic                              out_last_of_run,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [psr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [psr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int PW = $clog2(WINDOW);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  logic [PW-1:0]              ptr_r, ptr_nxt;
  logic [psr_pkg::SEQ_W-1:0]  last_r, last_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [psr_pkg::PAY_W-1:0]  out_pay_r, out_pay_nxt;
  logic [psr_pkg::SEQ_W-1:0]  out_seq_r, out_seq_nxt;
  logic                       out_fs_r, out_fs_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_load;

  psr_pkg::mode_t             mode;
  logic                       out_free;
  logic                       in_accept;
  logic [psr_pkg::SEQ_W-1:0]  off;
  logic [PW-1:0]              ptr_inc;
  logic [PW:0]                slot_sum;
  logic [PW-1:0]              slot;

  logic                       wr_en, clr_en, rd_en;
  logic [PW-1:0]              rd_addr;
  logic [psr_pkg::PAY_W-1:0]  rd_data;
  logic [WINDOW-1:0]          valid;

  psr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  psr_store #(
    .WINDOW (WINDOW),
    .PW     (PW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (slot),
    .wr_data  (in_payload_handle),
    .clr_en   (clr_en),
    .clr_addr (ptr_r),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .valid    (valid)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;

  // Distance of the arriving number from the expected one.
  assign off      = in_sequence_number - last_r - 32'd1;
  assign ptr_inc  = (ptr_r == PW'(WINDOW - 1)) ? '0 : ptr_r + PW'(1);
  assign slot_sum = {1'b0, ptr_r} + {1'b0, off[PW-1:0]};
  assign slot     = (slot_sum >= (PW+1)'(WINDOW)) ? PW'(slot_sum - (PW+1)'(WINDOW))
                                                  : slot_sum[PW-1:0];
  assign rd_addr  = ptr_inc;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pay_nxt   = out_pay_r;
    out_seq_nxt   = out_seq_r;
    out_fs_nxt    = out_fs_r;
    out_last_nxt  = out_last_r;
    out_load      = 1'b0;
    wr_en         = 1'b0;
    clr_en        = 1'b0;
    rd_en         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept && !mode.rx_disabled && !mode.ignore_in) begin
          if (mode.unreliable) begin
            out_load     = 1'b1;
            out_pay_nxt  = in_payload_handle;
            out_seq_nxt  = in_sequence_number;
            out_fs_nxt   = 1'b0;
            out_last_nxt = 1'b1;
          end else if (off == '0) begin
            out_load     = 1'b1;
            out_pay_nxt  = in_payload_handle;
            out_seq_nxt  = in_sequence_number;
            out_fs_nxt   = 1'b0;
            out_last_nxt = !valid[ptr_inc];
            clr_en       = 1'b1;
            ptr_nxt      = ptr_inc;
            last_nxt     = last_r + 32'd1;
            if (valid[ptr_inc]) begin
              rd_en     = 1'b1;
              state_nxt = ST_DRAIN;
            end
          end else if (off < 32'(WINDOW)) begin
            // A duplicate keeps the copy already held.
            wr_en = !valid[slot];
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_pay_nxt  = rd_data;
          out_seq_nxt  = last_r + 32'd1;
          out_fs_nxt   = 1'b1;
          out_last_nxt = !valid[ptr_inc];
          clr_en       = 1'b1;
          ptr_nxt      = ptr_inc;
          last_nxt     = last_r + 32'd1;
          if (valid[ptr_inc]) begin
            rd_en = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pay_r  <= out_pay_nxt;
    out_seq_r  <= out_seq_nxt;
    out_fs_r   <= out_fs_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_payload     = out_pay_r;
  assign out_sequence    = out_seq_r;
  assign out_from_store  = out_fs_r;
  assign out_last_of_run = out_last_r;

endmodule
